FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Expression holds at every clock edge, outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

FILE: rtl/pwlvi_pkg.sv
// Package for the voltage-to-current converter: widths, breakpoint table
// and per-segment constant helpers. Depends on nothing.
package pwlvi_pkg;

  localparam int unsigned IN_W        = 22;
  localparam int unsigned OUT_W       = 19;
  localparam int unsigned POINTS      = 20;
  localparam int unsigned SEGS        = POINTS - 1;
  localparam int unsigned SEG_IW      = $clog2(POINTS);
  // Widest segment in the table fits in DX_W bits
  localparam int unsigned DX_W        = 19;
  // Largest current step across one segment fits in DY_W bits
  localparam int unsigned DY_W        = 16;
  // Reciprocal scaling; must be at least DX_W so the quotient estimate is off by at most one
  localparam int unsigned RECIP_SHIFT = DX_W;
  localparam int unsigned K_W         = 16;
  localparam int unsigned Q_W         = DY_W;
  localparam int unsigned P_W         = DX_W + DY_W;

  localparam logic [IN_W-1:0] BP_VOLT [POINTS] = '{
    22'd45470,   22'd70411,   22'd139210,  22'd149846,  22'd154863,
    22'd194600,  22'd199260,  22'd578999,  22'd598937,  22'd623470,
    22'd628588,  22'd937611,  22'd1256687, 22'd1271388, 22'd1276470,
    22'd1555647, 22'd1605000, 22'd1929222, 22'd1934058, 22'd2047000
  };

  localparam logic signed [OUT_W-1:0] BP_CURR [POINTS] = '{
    19'sd9940,    19'sd7432,    19'sd414,     -19'sd556,    -19'sd1071,
    -19'sd5076,   -19'sd5572,   -19'sd43707,  -19'sd45770,  -19'sd48247,
    -19'sd48753,  -19'sd79809,  -19'sd111887, -19'sd113383, -19'sd113899,
    -19'sd142033, -19'sd146968, -19'sd179602, -19'sd180117, -19'sd193557
  };

  // Voltage span of one segment
  function automatic logic [DX_W-1:0] seg_width(input int unsigned s);
    logic [IN_W-1:0] d;
    d = BP_VOLT[s+1] - BP_VOLT[s];
    return d[DX_W-1:0];
  endfunction

  // Magnitude of the current step across one segment
  function automatic logic [DY_W-1:0] seg_rise(input int unsigned s);
    int d;
    d = int'(BP_CURR[s+1]) - int'(BP_CURR[s]);
    if (d < 0) d = -d;
    return DY_W'(d);
  endfunction

  // Current falls across the segment
  function automatic logic seg_falls(input int unsigned s);
    return BP_CURR[s+1] < BP_CURR[s];
  endfunction

endpackage

FILE: rtl/piecewise_linear_voltage_to_current.sv
// Throughput: one item per cycle; busy is never raised, as nothing here can stall.
// Rate is set by the six-stage pipeline: compare, encode, lookup, multiply,
// multiply-back, correct. Reset (rst_n low, synchronous) clears all valid bits.
// Depends on pwlvi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module piecewise_linear_voltage_to_current
  import pwlvi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [IN_W-1:0]         in_sample_microvolts,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_current_nanoamps
);

  // Per-segment constant tables
  logic [DX_W-1:0] w_tab   [SEGS];
  logic [DY_W-1:0] ady_tab [SEGS];
  logic            neg_tab [SEGS];
  logic [K_W-1:0]  k_tab   [SEGS];

  for (genvar g = 0; g < SEGS; g++) begin : g_seg
    // Scaled slope magnitude, rounded down
    localparam longint unsigned KV =
      (longint'(seg_rise(g)) << RECIP_SHIFT) / longint'(seg_width(g));
    assign w_tab[g]   = seg_width(g);
    assign ady_tab[g] = seg_rise(g);
    assign neg_tab[g] = seg_falls(g);
    assign k_tab[g]   = K_W'(KV);
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage registers
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [POINTS-1:0]        ge1_r, ge1_nxt;
  logic [IN_W-1:0]          x1_r, x2_r;
  logic [SEG_IW-1:0]        idx2_r, idx2_nxt;
  logic                     lo2_r, hi2_r;
  logic [DX_W-1:0]          dx3_r, dx3_nxt, w3_r, w4_r, w5_r;
  logic [K_W-1:0]           k3_r;
  logic [DY_W-1:0]          ady3_r;
  logic signed [OUT_W-1:0]  y03_r, y04_r, y05_r;
  logic                     neg3_r, neg4_r, neg5_r;
  logic [Q_W-1:0]           q4_r, q5_r;
  logic [P_W-1:0]           p4_r, p5_r, qw5_r;
  logic [K_W+DX_W-1:0]      mk4;
  logic [P_W-1:0]           rem6;
  logic [Q_W-1:0]           q6;
  logic signed [OUT_W-1:0]  y6_nxt, y6_r;

  // Compare the sample against every breakpoint
  always_comb begin
    for (int i = 0; i < POINTS; i++) begin
      ge1_nxt[i] = in_sample_microvolts >= BP_VOLT[i];
    end
  end

  // Encode the thermometer into a segment index
  always_comb begin
    idx2_nxt = '0;
    for (int i = 0; i < SEGS; i++) begin
      if (ge1_r[i] && !ge1_r[i+1]) idx2_nxt = idx2_nxt | SEG_IW'(i);
    end
    if (ge1_r[POINTS-1]) idx2_nxt = SEG_IW'(SEGS - 1);
  end

  // Offset into the segment; top clamp runs the full span, bottom clamp none
  always_comb begin
    logic [IN_W-1:0] diff;
    diff = x2_r - BP_VOLT[idx2_r];
    if (hi2_r) begin
      dx3_nxt = w_tab[idx2_r];
    end else if (lo2_r) begin
      dx3_nxt = '0;
    end else begin
      dx3_nxt = diff[DX_W-1:0];
    end
  end

  // Estimated quotient from the scaled slope
  assign mk4 = (K_W+DX_W)'(dx3_r) * (K_W+DX_W)'(k3_r);

  // Remainder check and final sum
  always_comb begin
    logic signed [OUT_W-1:0] qs;
    rem6 = p5_r - qw5_r;
    q6   = q5_r + Q_W'(rem6 >= P_W'(w5_r));
    qs   = $signed(OUT_W'(q6));
    y6_nxt = neg5_r ? (y05_r - qs) : (y05_r + qs);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    ge1_r  <= ge1_nxt;
    x1_r   <= in_sample_microvolts;

    x2_r   <= x1_r;
    idx2_r <= idx2_nxt;
    lo2_r  <= !ge1_r[0];
    hi2_r  <= ge1_r[POINTS-1];

    dx3_r  <= dx3_nxt;
    w3_r   <= w_tab[idx2_r];
    k3_r   <= k_tab[idx2_r];
    ady3_r <= ady_tab[idx2_r];
    neg3_r <= neg_tab[idx2_r];
    y03_r  <= BP_CURR[idx2_r];

    q4_r   <= mk4[RECIP_SHIFT +: Q_W];
    p4_r   <= P_W'(dx3_r) * P_W'(ady3_r);
    w4_r   <= w3_r;
    y04_r  <= y03_r;
    neg4_r <= neg3_r;

    qw5_r  <= P_W'(q4_r) * P_W'(w4_r);
    p5_r   <= p4_r;
    q5_r   <= q4_r;
    w5_r   <= w4_r;
    y05_r  <= y04_r;
    neg5_r <= neg4_r;

    y6_r   <= y6_nxt;
  end

  assign out_valid            = v6_r;
  assign out_current_nanoamps = y6_r;

  // Checks
  `ASSERT_IMPLIES(a_latency, clk, rst_n, out_valid, $past(start && !busy, 6), "result without item")
  `ASSERT_IMPLIES(a_offset, clk, rst_n, v3_r, dx3_r <= w3_r, "offset beyond segment")
  `ASSERT_IMPLIES(a_remainder, clk, rst_n, v5_r && p5_r >= qw5_r, rem6 < P_W'({w5_r, 1'b0}), "quotient estimate off by more than one")
  `ASSERT_IMPLIES(a_estimate, clk, rst_n, v5_r, p5_r >= qw5_r, "quotient estimate too large")

endmodule

FILE: test/tb_piecewise_linear_voltage_to_current.sv
// Testbench for the piecewise-linear voltage-to-current converter.
// Directed breakpoint and clamp items, then random samples, checked against a local table.
// Depends on pwlvi_pkg and the piecewise_linear_voltage_to_current RTL.
module tb_piecewise_linear_voltage_to_current;
  import pwlvi_pkg::*;

  localparam int KNEES         = 20;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int QUIET_ITEMS   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_LIMIT   = 2000;

  // Breakpoint table: voltage in microvolts and current in nanoamps
  localparam int KNEE_UV [KNEES] = '{
    45470, 70411, 139210, 149846, 154863, 194600, 199260, 578999, 598937,
    623470, 628588, 937611, 1256687, 1271388, 1276470, 1555647, 1605000,
    1929222, 1934058, 2047000
  };
  localparam int KNEE_NA [KNEES] = '{
    9940, 7432, 414, -556, -1071, -5076, -5572, -43707, -45770,
    -48247, -48753, -79809, -111887, -113383, -113899, -142033, -146968,
    -179602, -180117, -193557
  };

  // Expected currents in order of acceptance, plus coverage counts
  class current_scoreboard;
    logic signed [OUT_W-1:0] currents_due[$];
    int failures;
    int samples;
    int results;
    int below_first;
    int above_last;
    int on_knee;

    // Interpolate between the two knees around the sample, clamping at the ends
    function logic signed [OUT_W-1:0] interpolate_current(logic [IN_W-1:0] v);
      longint x;
      longint y;
      longint x0;
      longint x1;
      longint y0;
      longint y1;
      x = longint'(v);
      y = KNEE_NA[KNEES-1];
      if (x <= KNEE_UV[0]) begin
        y = KNEE_NA[0];
      end else if (x < KNEE_UV[KNEES-1]) begin
        for (int s = 0; s < KNEES - 1; s++) begin
          x0 = KNEE_UV[s];
          x1 = KNEE_UV[s+1];
          y0 = KNEE_NA[s];
          y1 = KNEE_NA[s+1];
          if (x >= x0 && x < x1) begin
            y = (x1 - x0 <= 0) ? y0 : y0 + ((x - x0) * (y1 - y0)) / (x1 - x0);
            break;
          end
        end
      end
      return OUT_W'(y);
    endfunction

    // Note an accepted sample and queue its current
    function void note_sample(logic [IN_W-1:0] v);
      samples++;
      if (v <= KNEE_UV[0]) below_first++;
      if (v >= KNEE_UV[KNEES-1]) above_last++;
      for (int k = 1; k < KNEES - 1; k++) begin
        if (v == KNEE_UV[k]) on_knee++;
      end
      currents_due.push_back(interpolate_current(v));
    endfunction

    // Compare a result with the oldest current due
    function void check_current(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      results++;
      if (currents_due.size() == 0) begin
        failures++;
        $error("current_nanoamps: no sample pending, got %0d", got);
      end else begin
        want = currents_due.pop_front();
        if (got !== want) begin
          failures++;
          $error("current_nanoamps: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return currents_due.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [IN_W-1:0]         in_sample_microvolts;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_current_nanoamps;

  current_scoreboard sb = new;
  int idle_pct;
  int stall_cycles;

  piecewise_linear_voltage_to_current i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_sample_microvolts (in_sample_microvolts),
    .out_valid            (out_valid),
    .out_current_nanoamps (out_current_nanoamps)
  );

  // Free-running clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watch both channels at every rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_sample(in_sample_microvolts);
    if (rst_n && out_valid) sb.check_current(out_current_nanoamps);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d currents outstanding",
               stall_cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item, idling at random first, and hold it until accepted
  task automatic drive_sample(input logic [IN_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_sample_microvolts <= IN_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_sample_microvolts <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold the sender until every queued current has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Draw a sample: mostly inside the table, some near knees and beyond the ends
  function automatic logic [IN_W-1:0] pick_sample();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = $urandom_range(KNEES - 1);
    if (r < 55) return IN_W'($urandom_range(KNEE_UV[KNEES-1], KNEE_UV[0]));
    if (r < 75) return IN_W'(KNEE_UV[k] + int'($urandom_range(6)) - 3);
    if (r < 85) return IN_W'($urandom_range(KNEE_UV[0]));
    if (r < 92) return IN_W'($urandom_range((1 << IN_W) - 1, KNEE_UV[KNEES-1]));
    return IN_W'($urandom);
  endfunction

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_sample_microvolts <= '0;
    idle_pct = 11;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Hit every knee exactly, then the ends of the input range and points beside the outer knees
    foreach (KNEE_UV[k]) drive_sample(IN_W'(KNEE_UV[k]));
    drive_sample('0);
    drive_sample(IN_W'(KNEE_UV[0] + 1));
    drive_sample(IN_W'(KNEE_UV[KNEES-1] - 1));
    drive_sample(IN_W'(KNEE_UV[KNEES-1] + 1));
    drive_sample('1);
    hold_until_drained();

    // Random samples: a back-to-back stretch first, then with idling
    idle_pct = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == QUIET_ITEMS) idle_pct = 11;
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      drive_sample(pick_sample());
    end

    // Drain, then allow the pipeline to settle
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d samples against %0d currents", sb.samples, sb.results);
    $display("Clamped low %0d, clamped high %0d, exact inner knees %0d",
             sb.below_first, sb.above_last, sb.on_knee);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
